FILE: design/tqm_pkg.sv
package tqm_pkg;

	localparam int MAX_TIMERS  = 16;
	localparam int MAX_RESULTS = 16;

	// Command codes.
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_CANCELED  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_EXPIRED   = 3'd4;
	localparam logic [2:0] ST_NONE      = 3'd5;

	typedef struct packed {
		logic [1:0]  command;
		logic [47:0] expire_time;
		logic [31:0] interval_us;
		logic [31:0] cancel_id;
		logic [47:0] now_time;
	} tqm_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] timer_id;
		logic        earliest_changed;
		logic [47:0] next_expiry;
		logic        next_valid;
		logic        last;
	} tqm_out_t;

	// What a walk over the table looks for.
	typedef enum logic [2:0] {
		WK_MIN,
		WK_ADD,
		WK_CANCEL,
		WK_PICK,
		WK_REARM
	} walk_kind_t;

	typedef struct packed {
		logic       load;
		logic       walk_start;
		walk_kind_t walk_kind;
		logic       commit_add;
		logic       commit_cancel;
		logic       commit_pick;
		logic       take_min;
		logic       emit_start;
		logic       emit_load;
	} tqm_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       walk_done;
		logic       found;
		logic       more;
		logic       has_exp;
		logic       can_emit;
		logic       emit_last;
	} tqm_stat_t;

endpackage

FILE: design/timer_queue_manager_unit.sv
// Ordered timer queue with a table of MAX_TIMERS slots. An item is one command:
// add stores a timer in the lowest free slot and returns a fresh id, cancel
// removes the lowest slot holding an id, and tick emits every timer due at the
// given time in order of expiry then id (at most MAX_RESULTS per tick), rearming
// repeating timers at now plus interval, saturated to 48 bits. Every result
// carries the earliest expiry left after the command. The block works on one
// item at a time; all work is done by walks over the slot table that read one
// slot per cycle from the table memories, so the cost is counted in walks.
// An add takes one walk and a cancel takes two walks; a tick with r expired
// timers takes r + 1 selection walks (r when it stops at MAX_RESULTS), a
// rearm pass over the r picked slots if r is not zero, and one final walk,
// before its results are delivered. No clearing pass is needed after reset.
// Results leave through an output register, so the last result of an item
// may wait there while the next item is taken.
module timer_queue_manager_unit #(
	parameter int MAX_TIMERS = tqm_pkg::MAX_TIMERS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  tqm_pkg::tqm_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tqm_pkg::tqm_out_t rsp
);

	// Commands from the sequencer and status back from the slot table.
	tqm_pkg::tqm_cmd_t  cmd;
	tqm_pkg::tqm_stat_t stat;

	tqm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the slot table, the walk pointer, the tick's pick
	// list and the output register.
	tqm_datapath #(
		.MAX_TIMERS (MAX_TIMERS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

FILE: design/tqm_datapath.sv
module tqm_datapath #(
	parameter int MAX_TIMERS = tqm_pkg::MAX_TIMERS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tqm_pkg::tqm_in_t  req,
	input  tqm_pkg::tqm_cmd_t cmd,
	output tqm_pkg::tqm_stat_t stat,
	input  logic              rsp_stall,
	output logic              rsp_valid,
	output tqm_pkg::tqm_out_t rsp
);

	localparam int MR = tqm_pkg::MAX_RESULTS;
	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int KW = $clog2(MR);
	localparam int NW = $clog2(MR + 1);
	localparam int PW = (IW > KW) ? IW : KW;

	tqm_pkg::tqm_in_t in_q;

	logic [MAX_TIMERS-1:0] valid_q;
	logic [MAX_TIMERS-1:0] taken_q;
	logic [47:0]           exp_mem [MAX_TIMERS];
	logic [31:0]           int_mem [MAX_TIMERS];
	logic [31:0]           id_mem  [MAX_TIMERS];
	logic [31:0]           id_ctr_q;

	logic [IW-1:0] order_q    [MR];
	logic [31:0]   order_id_q [MR];
	logic [NW-1:0] n_q;

	logic                  walking_q;
	tqm_pkg::walk_kind_t   kind_q;
	logic [PW-1:0]         ptr_q;
	logic                  act_s1;
	logic [IW-1:0]         slot_s1;
	logic [47:0]           exp_s1;
	logic [31:0]           int_s1;
	logic [31:0]           id_s1;

	logic          best_found_q;
	logic [47:0]   best_exp_q;
	logic [31:0]   best_id_q;
	logic [IW-1:0] best_slot_q;
	logic          free_found_q;
	logic [IW-1:0] free_slot_q;
	logic          match_found_q;
	logic [IW-1:0] match_slot_q;

	logic [47:0] nx_q;
	logic        nv_q;
	logic        changed_q;
	logic        full_q;
	logic        found_q;
	logic [31:0] res_id_q;
	logic [KW-1:0] k_q;

	logic              rsp_valid_q;
	tqm_pkg::tqm_out_t rsp_q;

	logic [IW-1:0] rd_slot;
	logic          walk_last;
	logic          v1;
	logic          t1;
	logic          min_upd;
	logic          pick_upd;
	logic          free_upd;
	logic          match_upd;
	logic          rearm_act;
	logic [48:0]   rearm_sum;
	logic [47:0]   rearm_exp;
	logic          add_wr;
	logic          exp_we;
	logic [IW-1:0] exp_wa;
	logic [47:0]   exp_wd;
	logic [NW:0]   n_inc;
	tqm_pkg::tqm_out_t res;

	assign rd_slot = (kind_q == tqm_pkg::WK_REARM) ? order_q[ptr_q[KW-1:0]] : ptr_q[IW-1:0];
	assign walk_last = (kind_q == tqm_pkg::WK_REARM) ?
		(ptr_q == PW'(n_q - NW'(1))) : (ptr_q == PW'(MAX_TIMERS - 1));

	assign v1 = valid_q[slot_s1];
	assign t1 = taken_q[slot_s1];
	assign min_upd = act_s1 && (kind_q == tqm_pkg::WK_MIN || kind_q == tqm_pkg::WK_ADD) &&
		v1 && (!best_found_q || exp_s1 < best_exp_q);
	assign pick_upd = act_s1 && kind_q == tqm_pkg::WK_PICK && v1 && !t1 &&
		exp_s1 <= in_q.now_time &&
		(!best_found_q || exp_s1 < best_exp_q || (exp_s1 == best_exp_q && id_s1 < best_id_q));
	assign free_upd = act_s1 && kind_q == tqm_pkg::WK_ADD && !v1 && !free_found_q;
	assign match_upd = act_s1 && kind_q == tqm_pkg::WK_CANCEL && v1 &&
		id_s1 == in_q.cancel_id && !match_found_q;

	// Repeating timers come back at now plus interval, saturated to 48 bits.
	assign rearm_act = act_s1 && kind_q == tqm_pkg::WK_REARM;
	assign rearm_sum = {1'b0, in_q.now_time} + {17'b0, int_s1};
	assign rearm_exp = rearm_sum[48] ? '1 : rearm_sum[47:0];

	assign add_wr = cmd.commit_add && free_found_q;
	assign exp_we = add_wr || (rearm_act && int_s1 != 32'd0);
	assign exp_wa = add_wr ? free_slot_q : slot_s1;
	assign exp_wd = add_wr ? in_q.expire_time : rearm_exp;

	assign n_inc = {1'b0, n_q} + (NW + 1)'(1);

	always_ff @(posedge clk) begin
		exp_s1 <= exp_mem[rd_slot];
		int_s1 <= int_mem[rd_slot];
		id_s1  <= id_mem[rd_slot];
		if (exp_we) begin
			exp_mem[exp_wa] <= exp_wd;
		end
		if (add_wr) begin
			int_mem[free_slot_q] <= in_q.interval_us;
			id_mem[free_slot_q]  <= id_ctr_q;
		end
	end

	always_comb begin
		res = '0;
		res.next_expiry = nx_q;
		res.next_valid  = nv_q;
		res.last        = stat.emit_last;
		case (in_q.command)
			tqm_pkg::CMD_ADD: begin
				res.status           = full_q ? tqm_pkg::ST_FULL : tqm_pkg::ST_ADDED;
				res.timer_id         = full_q ? 32'd0 : res_id_q;
				res.earliest_changed = changed_q;
			end
			tqm_pkg::CMD_CANCEL: begin
				res.status   = found_q ? tqm_pkg::ST_CANCELED : tqm_pkg::ST_NOT_FOUND;
				res.timer_id = in_q.cancel_id;
			end
			default: begin
				res.status   = (n_q == '0) ? tqm_pkg::ST_NONE : tqm_pkg::ST_EXPIRED;
				res.timer_id = (n_q == '0) ? 32'd0 : order_id_q[k_q];
			end
		endcase
	end

	always_comb begin
		stat.command   = in_q.command;
		stat.walk_done = !walking_q && !act_s1;
		stat.found     = best_found_q;
		stat.more      = n_inc < (NW + 1)'(MR);
		stat.has_exp   = n_q != '0;
		stat.can_emit  = !rsp_valid_q || !rsp_stall;
		stat.emit_last = (in_q.command == tqm_pkg::CMD_TICK && n_q != '0) ?
			(k_q == KW'(n_q - NW'(1))) : 1'b1;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			taken_q       <= '0;
			id_ctr_q      <= 32'd1;
			n_q           <= '0;
			walking_q     <= 1'b0;
			kind_q        <= tqm_pkg::WK_MIN;
			ptr_q         <= '0;
			act_s1        <= 1'b0;
			best_found_q  <= 1'b0;
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			k_q           <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				taken_q <= '0;
				n_q     <= '0;
			end
			act_s1 <= walking_q;
			if (min_upd || pick_upd) begin
				best_found_q <= 1'b1;
			end
			if (free_upd) begin
				free_found_q <= 1'b1;
			end
			if (match_upd) begin
				match_found_q <= 1'b1;
			end
			if (rearm_act && int_s1 == 32'd0) begin
				valid_q[slot_s1] <= 1'b0;
			end
			if (add_wr) begin
				valid_q[free_slot_q] <= 1'b1;
				id_ctr_q             <= id_ctr_q + 32'd1;
			end
			if (cmd.commit_cancel && match_found_q) begin
				valid_q[match_slot_q] <= 1'b0;
			end
			if (cmd.commit_pick) begin
				taken_q[best_slot_q] <= 1'b1;
				n_q                  <= n_inc[NW-1:0];
			end
			if (cmd.walk_start) begin
				walking_q     <= 1'b1;
				ptr_q         <= '0;
				kind_q        <= cmd.walk_kind;
				best_found_q  <= 1'b0;
				free_found_q  <= 1'b0;
				match_found_q <= 1'b0;
			end else if (walking_q) begin
				ptr_q <= ptr_q + PW'(1);
				if (walk_last) begin
					walking_q <= 1'b0;
				end
			end
			if (cmd.emit_start) begin
				k_q <= '0;
			end
			if (cmd.emit_load) begin
				k_q         <= k_q + KW'(1);
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= req;
		end
		slot_s1 <= rd_slot;
		if (min_upd || pick_upd) begin
			best_exp_q  <= exp_s1;
			best_id_q   <= id_s1;
			best_slot_q <= slot_s1;
		end
		if (free_upd) begin
			free_slot_q <= slot_s1;
		end
		if (match_upd) begin
			match_slot_q <= slot_s1;
		end
		if (cmd.commit_pick) begin
			order_q[n_q[KW-1:0]]    <= best_slot_q;
			order_id_q[n_q[KW-1:0]] <= best_id_q;
		end
		if (cmd.commit_add) begin
			full_q    <= !free_found_q;
			res_id_q  <= id_ctr_q;
			changed_q <= free_found_q && (!best_found_q || in_q.expire_time < best_exp_q);
			if (free_found_q) begin
				nv_q <= 1'b1;
				nx_q <= (best_found_q && best_exp_q <= in_q.expire_time) ?
					best_exp_q : in_q.expire_time;
			end else begin
				nv_q <= best_found_q;
				nx_q <= best_found_q ? best_exp_q : 48'd0;
			end
		end
		if (cmd.commit_cancel) begin
			found_q   <= match_found_q;
			changed_q <= 1'b0;
		end
		if (cmd.take_min) begin
			nv_q <= best_found_q;
			nx_q <= best_found_q ? best_exp_q : 48'd0;
		end
		if (cmd.emit_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MR))
		else $error("expired count beyond result limit");
	a_walk_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		walking_q |=> act_s1)
		else $error("walk read lost its evaluation stage");
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("result overwritten while stalled");
	a_pick_new: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_pick |-> (best_found_q && !taken_q[best_slot_q]))
		else $error("timer picked twice in one tick");
`endif

endmodule

FILE: design/tqm_ctrl.sv
module tqm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  tqm_pkg::tqm_stat_t stat,
	output tqm_pkg::tqm_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_WALK,
		S_CAN_WALK,
		S_PICK_WALK,
		S_REARM_WALK,
		S_MIN_WALK,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.walk_kind = tqm_pkg::WK_MIN;
		state_d   = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.command)
					tqm_pkg::CMD_ADD: begin
						cmd.walk_start = 1'b1;
						cmd.walk_kind  = tqm_pkg::WK_ADD;
						state_d        = S_ADD_WALK;
					end
					tqm_pkg::CMD_CANCEL: begin
						cmd.walk_start = 1'b1;
						cmd.walk_kind  = tqm_pkg::WK_CANCEL;
						state_d        = S_CAN_WALK;
					end
					tqm_pkg::CMD_TICK: begin
						cmd.walk_start = 1'b1;
						cmd.walk_kind  = tqm_pkg::WK_PICK;
						state_d        = S_PICK_WALK;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ADD_WALK: begin
				if (stat.walk_done) begin
					cmd.commit_add = 1'b1;
					cmd.emit_start = 1'b1;
					state_d        = S_EMIT;
				end
			end
			S_CAN_WALK: begin
				if (stat.walk_done) begin
					cmd.commit_cancel = 1'b1;
					cmd.walk_start    = 1'b1;
					cmd.walk_kind     = tqm_pkg::WK_MIN;
					state_d           = S_MIN_WALK;
				end
			end
			S_PICK_WALK: begin
				if (stat.walk_done) begin
					cmd.walk_start = 1'b1;
					if (stat.found) begin
						cmd.commit_pick = 1'b1;
						if (stat.more) begin
							cmd.walk_kind = tqm_pkg::WK_PICK;
						end else begin
							cmd.walk_kind = tqm_pkg::WK_REARM;
							state_d       = S_REARM_WALK;
						end
					end else if (stat.has_exp) begin
						cmd.walk_kind = tqm_pkg::WK_REARM;
						state_d       = S_REARM_WALK;
					end else begin
						cmd.walk_kind = tqm_pkg::WK_MIN;
						state_d       = S_MIN_WALK;
					end
				end
			end
			S_REARM_WALK: begin
				if (stat.walk_done) begin
					cmd.walk_start = 1'b1;
					cmd.walk_kind  = tqm_pkg::WK_MIN;
					state_d        = S_MIN_WALK;
				end
			end
			S_MIN_WALK: begin
				if (stat.walk_done) begin
					cmd.take_min   = 1'b1;
					cmd.emit_start = 1'b1;
					state_d        = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.can_emit) begin
					cmd.emit_load = 1'b1;
					if (stat.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE)
		else $error("item taken while busy");
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> state_q == S_EMIT)
		else $error("result issued outside emit");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import tqm_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	tqm_in_t req;
	logic rsp_valid;
	logic rsp_stall;
	tqm_out_t rsp;

	timer_queue_manager_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Shadow copy of the timer table, kept in step with every accepted item.
	logic        tbl_valid [MAX_TIMERS];
	logic [47:0] tbl_expiry [MAX_TIMERS];
	logic [31:0] tbl_interval [MAX_TIMERS];
	logic [31:0] tbl_id [MAX_TIMERS];
	logic [31:0] next_id;

	tqm_in_t  pending_cmds [$];
	tqm_out_t due_results [$];
	logic [31:0] issued_ids [$];

	int mismatches = 0;
	int checked = 0;
	int accepted = 0;
	int popped = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	bit quiet_mode = 0;
	bit hold_sender = 0;
	bit stim_done = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Earliest armed expiry in the shadow table.
	function automatic logic table_min(output logic [47:0] when);
		logic any;
		any = 0;
		when = '0;
		for (int i = 0; i < MAX_TIMERS; i++)
			if (tbl_valid[i] && (!any || tbl_expiry[i] < when)) begin
				when = tbl_expiry[i];
				any = 1;
			end
		return any;
	endfunction

	// Apply one command to the shadow table and queue what the block must return.
	task automatic predict_timers(input tqm_in_t c);
		logic [47:0] cur, nx;
		logic had, nv, found, chg;
		logic [48:0] sum;
		int fs, pick, n;
		int order [MAX_RESULTS];
		logic taken [MAX_TIMERS];
		tqm_out_t r;
		r = '0;
		case (c.command)
			CMD_ADD: begin
				had = table_min(cur);
				fs = -1;
				for (int i = MAX_TIMERS - 1; i >= 0; i--)
					if (!tbl_valid[i]) fs = i;
				if (fs < 0) begin
					r.status = ST_FULL;
				end else begin
					chg = !had || c.expire_time < cur;
					tbl_valid[fs] = 1;
					tbl_expiry[fs] = c.expire_time;
					tbl_interval[fs] = c.interval_us;
					tbl_id[fs] = next_id;
					issued_ids.push_back(next_id);
					r.status = ST_ADDED;
					r.timer_id = next_id;
					r.earliest_changed = chg;
					next_id = next_id + 1;
				end
				r.next_valid = table_min(nx);
				r.next_expiry = nx;
				r.last = 1;
				due_results.push_back(r);
			end
			CMD_CANCEL: begin
				found = 0;
				for (int i = 0; i < MAX_TIMERS; i++)
					if (!found && tbl_valid[i] && tbl_id[i] == c.cancel_id) begin
						tbl_valid[i] = 0;
						found = 1;
					end
				r.status = found ? ST_CANCELED : ST_NOT_FOUND;
				r.timer_id = c.cancel_id;
				r.next_valid = table_min(nx);
				r.next_expiry = nx;
				r.last = 1;
				due_results.push_back(r);
			end
			CMD_TICK: begin
				n = 0;
				for (int i = 0; i < MAX_TIMERS; i++) taken[i] = 0;
				while (n < MAX_RESULTS) begin
					pick = -1;
					for (int i = 0; i < MAX_TIMERS; i++) begin
						if (!tbl_valid[i] || taken[i] || tbl_expiry[i] > c.now_time) continue;
						if (pick < 0 || tbl_expiry[i] < tbl_expiry[pick] ||
								(tbl_expiry[i] == tbl_expiry[pick] && tbl_id[i] < tbl_id[pick]))
							pick = i;
					end
					if (pick < 0) break;
					taken[pick] = 1;
					order[n] = pick;
					n++;
				end
				// Repeating timers are rearmed, saturating at the top of the 48-bit range.
				for (int k = 0; k < n; k++) begin
					if (tbl_interval[order[k]] != 0) begin
						sum = {1'b0, c.now_time} + tbl_interval[order[k]];
						tbl_expiry[order[k]] = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
					end else begin
						tbl_valid[order[k]] = 0;
					end
				end
				nv = table_min(nx);
				r.next_valid = nv;
				r.next_expiry = nx;
				if (n == 0) begin
					r.status = ST_NONE;
					r.last = 1;
					due_results.push_back(r);
				end
				for (int k = 0; k < n; k++) begin
					r.status = ST_EXPIRED;
					r.timer_id = tbl_id[order[k]];
					r.last = (k == n - 1);
					due_results.push_back(r);
				end
			end
			default: ;
		endcase
	endtask

	function automatic tqm_in_t make_cmd(logic [1:0] op, logic [47:0] t,
			logic [31:0] iv, logic [31:0] id);
		tqm_in_t c;
		c.command = op;
		c.expire_time = t;
		c.interval_us = iv;
		c.cancel_id = id;
		c.now_time = t;
		return c;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom_range(65535, 0)), $urandom()};
	endfunction

	// Random fill of the unused fields keeps every payload bit moving.
	function automatic tqm_in_t noisy_cmd(logic [1:0] op, logic [47:0] t,
			logic [31:0] iv, logic [31:0] id);
		tqm_in_t c;
		c = make_cmd(op, t, iv, id);
		if (op == CMD_TICK) c.expire_time = rand48();
		else c.now_time = rand48();
		if (op != CMD_ADD) c.interval_us = $urandom();
		if (op != CMD_CANCEL) c.cancel_id = $urandom();
		return c;
	endfunction

	// Driver: present the head of the pending queue, hold it while stalled.
	// The monitor counts acceptances at the rising edge; the driver retires
	// the accepted item here.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 0;
		end else if (popped < accepted) begin
			popped++;
			void'(pending_cmds.pop_front());
			if (pending_cmds.size() > 0 && !hold_sender &&
					(quiet_mode || $urandom_range(99, 0) >= 9)) begin
				req <= pending_cmds[0];
				req_valid <= 1;
			end else begin
				req_valid <= 0;
			end
		end else if (!req_valid && pending_cmds.size() > 0 && !hold_sender &&
				(quiet_mode || $urandom_range(99, 0) >= 9)) begin
			req <= pending_cmds[0];
			req_valid <= 1;
		end
		rsp_stall <= quiet_mode ? 1'b0 : ($urandom_range(99, 0) < 9);
	end

	// Monitor: predict each accepted item and compare each delivered result
	// with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (req_valid && !req_stall) begin
				predict_timers(req);
				accepted++;
			end
			if (rsp_valid && !rsp_stall) begin
				checked++;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result %p", rsp);
				end else begin
					if (rsp !== due_results[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %p, got %p", due_results[0], rsp);
					end
					void'(due_results.pop_front());
				end
			end
			if (idle_cycles > IDLE_LIMIT) timed_out = 1;
		end
	end

	task automatic wait_drained();
		while ((pending_cmds.size() > 0 || req_valid || due_results.size() > 0) && !timed_out)
			@(posedge clk);
	endtask

	// Random id to cancel: mostly one handed out before, sometimes anything.
	function automatic logic [31:0] pick_cancel_id();
		if (issued_ids.size() > 0 && $urandom_range(3, 0) != 0)
			return issued_ids[$urandom_range(issued_ids.size() - 1, 0)];
		return $urandom();
	endfunction

	initial begin
		logic [47:0] clock_now;
		int r;
		arst_n = 0;
		req_valid = 0;
		rsp_stall = 0;
		req = '0;
		for (int i = 0; i < MAX_TIMERS; i++) begin
			tbl_valid[i] = 0;
			tbl_expiry[i] = '0;
			tbl_interval[i] = '0;
			tbl_id[i] = '0;
		end
		next_id = 1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: tick on an empty table, adds at the extremes, equal expiry,
		// unknown command, cancel of a missing id, a full table and ties.
		pending_cmds.push_back(make_cmd(CMD_TICK, '0, '0, '0));
		pending_cmds.push_back(make_cmd(CMD_ADD, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0));
		pending_cmds.push_back(make_cmd(CMD_ADD, 48'd100, 32'd0, '0));
		pending_cmds.push_back(make_cmd(CMD_ADD, 48'd100, 32'd50, '0));
		pending_cmds.push_back(make_cmd(CMD_ADD, 48'd0, 32'd0, '0));
		pending_cmds.push_back(make_cmd(2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_cmds.push_back(make_cmd(CMD_CANCEL, '0, '0, 32'hFFFF_FFFF));
		pending_cmds.push_back(make_cmd(CMD_CANCEL, '0, '0, 32'd3));
		pending_cmds.push_back(make_cmd(CMD_TICK, 48'd100, '0, '0));
		pending_cmds.push_back(make_cmd(CMD_TICK, 48'hFFFF_FFFF_FFFF, '0, '0));
		for (int i = 0; i < MAX_TIMERS + 1; i++)
			pending_cmds.push_back(make_cmd(CMD_ADD, 48'd500, (i % 2) ? 32'd7 : 32'd0, '0));
		pending_cmds.push_back(make_cmd(CMD_TICK, 48'd600, '0, '0));
		wait_drained();

		// Hold the sender back with an item pending, then release it.
		hold_sender = 1;
		pending_cmds.push_back(make_cmd(CMD_TICK, 48'hFFFF_FFFF_FFFF, '0, '0));
		repeat (40) @(posedge clk);
		hold_sender = 0;
		wait_drained();

		// Random sessions: a clock that moves forward, adds near it, cancels mostly of
		// known ids and ticks, with occasional out-of-range times and noise.
		clock_now = rand48() >> 8;
		for (int n = 0; n < 320 && !timed_out; n++) begin
			quiet_mode = (n >= 120 && n < 180);
			r = $urandom_range(99, 0);
			if (r < 40) begin
				pending_cmds.push_back(noisy_cmd(CMD_ADD,
					($urandom_range(9, 0) == 0) ? rand48() : clock_now + $urandom_range(2000, 0),
					($urandom_range(2, 0) == 0) ? 32'd0 :
					(($urandom_range(9, 0) == 0) ? $urandom() : $urandom_range(1500, 1)),
					'0));
			end else if (r < 60) begin
				pending_cmds.push_back(noisy_cmd(CMD_CANCEL, '0, '0, pick_cancel_id()));
			end else if (r < 97) begin
				clock_now = clock_now + $urandom_range(800, 0);
				pending_cmds.push_back(noisy_cmd(CMD_TICK,
					($urandom_range(19, 0) == 0) ? rand48() : clock_now, '0, '0));
			end else begin
				pending_cmds.push_back(noisy_cmd(2'd3, rand48(), $urandom(), $urandom()));
			end
			if (pending_cmds.size() > 8) wait_drained();
		end
		wait_drained();
		stim_done = 1;
		repeat (60) @(posedge clk);

		if (timed_out) begin
			$display("FAILED: results differ");
		end else begin
			$display("Covered %0d commands and %0d results, including a full table, ties,",
				accepted, checked);
			$display("rearm saturation, unknown ids and random stalls on both channels.");
			if (mismatches == 0 && due_results.size() == 0)
				$display("PASSED: all results match");
			else
				$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: timer_queue_manager_unit.f
design/tqm_pkg.sv
design/tqm_datapath.sv
design/tqm_ctrl.sv
design/timer_queue_manager_unit.sv
tb/sv/tb.sv
